// ----- rtl/jhte_pkg.sv -----
// types and constants shared by the huffman table engine modules
`default_nettype none
package jhte_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;
  localparam logic [1:0] OP_ENCODE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SYM_W-1:0]  found_symbol;
    logic [CODE_W-1:0] found_code;
    logic [LEN_W-1:0]  found_length;
  } out_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              len_ok;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] want;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/jhte_front.sv -----
// front end: classifies incoming beats into commands
`default_nettype none
module jhte_front #(
  parameter int MAX_CODE_LENGTH = 16
) (
  input  wire logic         in_push,
  output logic              in_full,
  input  wire jhte_pkg::in_t in_data,
  output logic              q_push,
  output jhte_pkg::cmd_t    q_data,
  input  wire logic         q_full
);
  import jhte_pkg::*;

  logic [CODE_W-1:0] mask;

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      mask[i] = (LEN_W'(i) < in_data.code_length);
    end
  end

  always_comb begin
    q_data.op     = in_data.operation;
    q_data.len    = in_data.code_length;
    q_data.symbol = in_data.symbol;
    q_data.want   = in_data.code_bits & mask;
    q_data.len_ok = (in_data.code_length != '0) &&
                    (in_data.code_length <= LEN_W'(MAX_CODE_LENGTH));
  end

  assign in_full = q_full;
  assign q_push  = in_push & ~q_full;

endmodule
`default_nettype wire

// ----- rtl/jhte_cmd_fifo.sv -----
// two-entry command queue between front and back
`default_nettype none
module jhte_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire jhte_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output jhte_pkg::cmd_t      pop_data
);
  import jhte_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jhte_back.sv -----
// back end: table state, stores and lookups
`default_nettype none
module jhte_back #(
  parameter int MAX_ENTRIES     = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire jhte_pkg::cmd_t q_data,
  output logic                q_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output jhte_pkg::out_t      out_data
);
  import jhte_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int LW = $clog2(MAX_CODE_LENGTH);

  logic [SYM_W-1:0]        sym_mem [MAX_ENTRIES];
  logic [CODE_W+LEN_W-1:0] map_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] map_valid_r, map_valid_nxt;

  logic [IW-1:0]     first_idx_r  [MAX_CODE_LENGTH];
  logic [IW:0]       count_r      [MAX_CODE_LENGTH];
  logic [CODE_W-1:0] first_code_r [MAX_CODE_LENGTH];

  logic [CODE_W:0]  next_code_r;
  logic [LEN_W-1:0] cur_len_r;
  logic [IW:0]      total_r;

  logic             busy_r, out_valid_r;
  out_t             out_r, out_nxt;
  logic [1:0]       p_op_r;
  logic [1:0]       p_status_r;
  logic [CODE_W-1:0] p_code_r;
  logic [LEN_W-1:0] p_len_r;
  logic             p_map_valid_r;
  logic [SYM_W-1:0] sym_rd_r;
  logic [CODE_W+LEN_W-1:0] map_rd_r;

  logic              issue;
  logic [LW-1:0]     li;
  logic [LEN_W-1:0]  shamt;
  logic [CODE_W:0]   code17;
  logic              app_ok;
  logic [1:0]        issue_status;
  logic [CODE_W-1:0] off;
  logic              hit;
  logic [IW-1:0]     dec_idx;

  assign issue = q_valid && !busy_r && (!out_valid_r || out_pop);
  assign q_pop = issue;
  assign out_empty = ~out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    li      = LW'(q_data.len - LEN_W'(1));
    shamt   = q_data.len - cur_len_r;
    code17  = next_code_r << shamt;
    off     = q_data.want - first_code_r[li];
    hit     = (count_r[li] != '0) && (q_data.want >= first_code_r[li]) &&
              (off < CODE_W'(count_r[li]));
    dec_idx = first_idx_r[li] + off[IW-1:0];
    app_ok  = 1'b0;
    issue_status = ST_OK;
    unique case (q_data.op)
      OP_CLEAR: issue_status = ST_OK;
      OP_APPEND: begin
        if (total_r == (IW+1)'(MAX_ENTRIES)) begin
          issue_status = ST_FULL;
        end else if (!q_data.len_ok || (q_data.len < cur_len_r) ||
                     ((code17 >> q_data.len) != '0)) begin
          issue_status = ST_INVALID;
        end else begin
          app_ok = 1'b1;
        end
      end
      OP_DECODE: issue_status = (q_data.len_ok && hit) ? ST_OK : ST_NOT_FOUND;
      OP_ENCODE: issue_status = ST_OK;
      default:   issue_status = ST_OK;
    endcase
  end

  always_comb begin
    map_valid_nxt = map_valid_r;
    if (issue && q_data.op == OP_CLEAR) begin
      map_valid_nxt = '0;
    end else if (issue && app_ok) begin
      map_valid_nxt[q_data.symbol] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      next_code_r <= '0;
      cur_len_r   <= '0;
      total_r     <= '0;
      for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      map_valid_r <= map_valid_nxt;
      if (issue && q_data.op == OP_CLEAR) begin
        next_code_r <= '0;
        cur_len_r   <= '0;
        total_r     <= '0;
        for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
          count_r[i] <= '0;
        end
      end else if (issue && app_ok) begin
        next_code_r <= code17 + (CODE_W+1)'(1);
        cur_len_r   <= q_data.len;
        total_r     <= total_r + (IW+1)'(1);
        count_r[li] <= count_r[li] + (IW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue && app_ok && count_r[li] == '0) begin
      first_idx_r[li]  <= total_r[IW-1:0];
      first_code_r[li] <= code17[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (issue && app_ok) begin
      sym_mem[total_r[IW-1:0]] <= q_data.symbol;
      map_mem[q_data.symbol]   <= {code17[CODE_W-1:0], q_data.len};
    end
    sym_rd_r <= sym_mem[dec_idx];
    map_rd_r <= map_mem[q_data.symbol];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_op_r        <= q_data.op;
      p_status_r    <= issue_status;
      p_code_r      <= app_ok ? code17[CODE_W-1:0] : q_data.want;
      p_len_r       <= q_data.len;
      p_map_valid_r <= map_valid_r[q_data.symbol];
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (p_op_r)
      OP_CLEAR: out_nxt = '0;
      OP_APPEND: begin
        out_nxt.status = p_status_r;
        if (p_status_r == ST_OK) begin
          out_nxt.found_code   = p_code_r;
          out_nxt.found_length = p_len_r;
        end
      end
      OP_DECODE: begin
        out_nxt.status = p_status_r;
        if (p_status_r == ST_OK) begin
          out_nxt.found_symbol = sym_rd_r;
          out_nxt.found_code   = p_code_r;
          out_nxt.found_length = p_len_r;
        end
      end
      OP_ENCODE: begin
        if (p_map_valid_r) begin
          out_nxt.status       = ST_OK;
          out_nxt.found_code   = map_rd_r[CODE_W+LEN_W-1:LEN_W];
          out_nxt.found_length = map_rd_r[LEN_W-1:0];
        end else begin
          out_nxt.status = ST_NOT_FOUND;
        end
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= issue;
      if (busy_r) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jpeg_huffman_table_engine.sv -----
// top level of the canonical huffman table engine
`default_nettype none
// Holds one canonical JPEG Huffman table. Each beat (clear, append, decode,
// encode) gives exactly one result beat. Beats enter a two-deep command queue
// and are executed one at a time, each result following the registered read
// of the symbol store (decode) or the code map (encode). The queue lets new
// beats be taken while a result waits to be popped.
module jpeg_huffman_table_engine #(
  parameter int MAX_ENTRIES     = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  output logic                in_full,
  input  wire jhte_pkg::in_t  in_data,
  output logic                out_empty,
  input  wire logic           out_pop,
  output jhte_pkg::out_t      out_data
);
  import jhte_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_in, q_out;

  jhte_front #(.MAX_CODE_LENGTH(MAX_CODE_LENGTH)) u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_data  (q_in),
    .q_full  (q_full)
  );

  jhte_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  jhte_back #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
